// File: sv/cam4_pkg.sv
package cam4_pkg;

  localparam int unsigned LEAF_W  = 32;
  localparam int unsigned TABLE_W = 16;

  // cofactor masks, one pair per variable
  localparam logic [TABLE_W-1:0] MASK_V0_LO = 16'h5555;
  localparam logic [TABLE_W-1:0] MASK_V0_HI = 16'hAAAA;
  localparam logic [TABLE_W-1:0] MASK_V1_LO = 16'h3333;
  localparam logic [TABLE_W-1:0] MASK_V1_HI = 16'hCCCC;
  localparam logic [TABLE_W-1:0] MASK_V2_LO = 16'h0F0F;
  localparam logic [TABLE_W-1:0] MASK_V2_HI = 16'hF0F0;
  localparam logic [TABLE_W-1:0] MASK_V3_LO = 16'h00FF;
  localparam logic [TABLE_W-1:0] MASK_V3_HI = 16'hFF00;
  localparam logic [TABLE_W-1:0] TABLE_ONES = 16'hFFFF;

  // input item: two cuts
  typedef struct packed {
    logic [2:0]  size_a;
    logic [63:0] leaves_a_low;
    logic [63:0] leaves_a_high;
    logic [15:0] table_a;
    logic        invert_a;
    logic [2:0]  size_b;
    logic [63:0] leaves_b_low;
    logic [63:0] leaves_b_high;
    logic [15:0] table_b;
    logic        invert_b;
  } cut_pair_t;

  // result item: merged cut
  typedef struct packed {
    logic        feasible;
    logic [2:0]  size_out;
    logic [63:0] leaves_out_low;
    logic [63:0] leaves_out_high;
    logic [15:0] table_out;
  } merge_result_t;

  // merge walk modes
  typedef enum logic [1:0] {
    WALK_MERGE   = 2'd0,
    WALK_FLUSH_A = 2'd1,
    WALK_FLUSH_B = 2'd2,
    WALK_FAIL    = 2'd3
  } walk_mode_t;

  // compare stage contents
  typedef struct packed {
    logic [3:0][3:0]        lt;
    logic [3:0][3:0]        eq;
    logic [2:0]             sa;
    logic [2:0]             sb;
    logic [3:0][LEAF_W-1:0] la;
    logic [3:0][LEAF_W-1:0] lb;
    logic [TABLE_W-1:0]     ta;
    logic [TABLE_W-1:0]     tb;
  } cmp_stage_t;

  // walk stage contents: variable maps and result slot sources
  typedef struct packed {
    logic                   fail;
    logic [2:0]             n;
    logic [3:0][1:0]        ma;
    logic [3:0][1:0]        mb;
    logic [3:0][2:0]        sel;
    logic [2:0]             sa;
    logic [2:0]             sb;
    logic [3:0][LEAF_W-1:0] la;
    logic [3:0][LEAF_W-1:0] lb;
    logic [TABLE_W-1:0]     ta;
    logic [TABLE_W-1:0]     tb;
  } walk_stage_t;

  // trim stage contents
  typedef struct packed {
    logic                   fail;
    logic [2:0]             n;
    logic [2:0]             k;
    logic [3:0][LEAF_W-1:0] res;
    logic [TABLE_W-1:0]     t;
  } trim_stage_t;

  // does the function depend on variable p
  function automatic logic var_matters(input logic [TABLE_W-1:0] t, input logic [1:0] p);
    logic r;
    unique case (p)
      2'd0: r = ((t & MASK_V0_HI) >> 1) != (t & MASK_V0_LO);
      2'd1: r = ((t & MASK_V1_HI) >> 2) != (t & MASK_V1_LO);
      2'd2: r = ((t & MASK_V2_HI) >> 4) != (t & MASK_V2_LO);
      default: r = ((t & MASK_V3_HI) >> 8) != (t & MASK_V3_LO);
    endcase
    return r;
  endfunction

  // remove variable p, taking the cofactor at 0 and moving higher ones down
  function automatic logic [TABLE_W-1:0] drop_var(input logic [TABLE_W-1:0] t,
                                                  input logic [1:0] p);
    logic [TABLE_W-1:0] r;
    logic [3:0]         mask;
    logic [3:0]         m;
    logic [3:0]         idx;
    r    = '0;
    mask = ~(4'hF << p);
    for (int i = 0; i < TABLE_W; i++) begin
      m    = 4'(i);
      idx  = (m & mask) | ((m & ~mask) << 1);
      r[i] = t[idx];
    end
    return r;
  endfunction

endpackage

// File: sv/cam4_merge.sv
module cam4_merge
  import cam4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  cut_pair_t   pair,
  output logic        out_valid,
  output walk_stage_t walk
);

  logic        cmp_valid;
  cmp_stage_t  cmp;
  cmp_stage_t  cmp_next;
  walk_stage_t walk_next;

  // unpack leaves, clamp sizes, apply inversions, compare all leaf pairs
  always_comb begin
    cmp_next.sa = (pair.size_a > 3'd4) ? 3'd4 : pair.size_a;
    cmp_next.sb = (pair.size_b > 3'd4) ? 3'd4 : pair.size_b;
    cmp_next.la[0] = pair.leaves_a_low[31:0];
    cmp_next.la[1] = pair.leaves_a_low[63:32];
    cmp_next.la[2] = pair.leaves_a_high[31:0];
    cmp_next.la[3] = pair.leaves_a_high[63:32];
    cmp_next.lb[0] = pair.leaves_b_low[31:0];
    cmp_next.lb[1] = pair.leaves_b_low[63:32];
    cmp_next.lb[2] = pair.leaves_b_high[31:0];
    cmp_next.lb[3] = pair.leaves_b_high[63:32];
    cmp_next.ta = pair.table_a ^ (pair.invert_a ? TABLE_ONES : '0);
    cmp_next.tb = pair.table_b ^ (pair.invert_b ? TABLE_ONES : '0);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        cmp_next.lt[i][j] = cmp_next.la[i] < cmp_next.lb[j];
        cmp_next.eq[i][j] = cmp_next.la[i] == cmp_next.lb[j];
      end
    end
  end

  // compare stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= in_valid;
    end
    cmp <= cmp_next;
  end

  // merge walk over the registered compare results
  always_comb begin
    logic [2:0] i;
    logic [2:0] j;
    logic [2:0] n;
    logic [3:0] total;
    logic [2:0] pos;
    walk_mode_t mode;
    i = '0;
    j = '0;
    n = '0;
    total = '0;
    pos = '0;
    walk_next.ma  = '0;
    walk_next.mb  = '0;
    walk_next.sel = '0;
    if (cmp.sa == 3'd0) begin
      mode = WALK_FLUSH_B;
    end else if (cmp.sb == 3'd0) begin
      mode = WALK_FLUSH_A;
    end else begin
      mode = WALK_MERGE;
    end
    for (int step = 0; step < 5; step++) begin
      if (mode == WALK_MERGE) begin
        if (n == 3'd4) begin
          mode = WALK_FAIL;
        end else if (cmp.lt[i[1:0]][j[1:0]]) begin
          walk_next.ma[i[1:0]] = n[1:0];
          walk_next.sel[n[1:0]] = {1'b0, i[1:0]};
          n = n + 3'd1;
          i = i + 3'd1;
          if (i >= cmp.sa) mode = WALK_FLUSH_B;
        end else if (!cmp.eq[i[1:0]][j[1:0]]) begin
          walk_next.mb[j[1:0]] = n[1:0];
          walk_next.sel[n[1:0]] = {1'b1, j[1:0]};
          n = n + 3'd1;
          j = j + 3'd1;
          if (j >= cmp.sb) mode = WALK_FLUSH_A;
        end else begin
          walk_next.ma[i[1:0]] = n[1:0];
          walk_next.mb[j[1:0]] = n[1:0];
          walk_next.sel[n[1:0]] = {1'b0, i[1:0]};
          n = n + 3'd1;
          i = i + 3'd1;
          j = j + 3'd1;
          if (i >= cmp.sa) begin
            mode = WALK_FLUSH_B;
          end else if (j >= cmp.sb) begin
            mode = WALK_FLUSH_A;
          end
        end
      end
    end
    // append the rest of the list that is left
    unique case (mode)
      WALK_FLUSH_A: begin
        total = {1'b0, n} + {1'b0, cmp.sa} - {1'b0, i};
        if (total > 4'd4) begin
          mode = WALK_FAIL;
        end else begin
          for (int q = 0; q < 4; q++) begin
            if (3'(q) >= i && 3'(q) < cmp.sa) begin
              pos = n + 3'(q) - i;
              walk_next.ma[q] = pos[1:0];
              walk_next.sel[pos[1:0]] = {1'b0, 2'(q)};
            end
          end
          n = total[2:0];
        end
      end
      WALK_FLUSH_B: begin
        total = {1'b0, n} + {1'b0, cmp.sb} - {1'b0, j};
        if (total > 4'd4) begin
          mode = WALK_FAIL;
        end else begin
          for (int q = 0; q < 4; q++) begin
            if (3'(q) >= j && 3'(q) < cmp.sb) begin
              pos = n + 3'(q) - j;
              walk_next.mb[q] = pos[1:0];
              walk_next.sel[pos[1:0]] = {1'b1, 2'(q)};
            end
          end
          n = total[2:0];
        end
      end
      default: begin
      end
    endcase
    walk_next.fail = (mode == WALK_FAIL);
    walk_next.n    = n;
    walk_next.sa   = cmp.sa;
    walk_next.sb   = cmp.sb;
    walk_next.la   = cmp.la;
    walk_next.lb   = cmp.lb;
    walk_next.ta   = cmp.ta;
    walk_next.tb   = cmp.tb;
  end

  // walk stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmp_valid;
    end
    walk <= walk_next;
  end

endmodule

// File: sv/cam4_expand.sv
module cam4_expand
  import cam4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  walk_stage_t walk,
  output logic        out_valid,
  output trim_stage_t trim
);

  trim_stage_t trim_next;

  // gather union leaves and AND both tables over the union variables
  always_comb begin
    logic [3:0]         m;
    logic [3:0]         idx_a;
    logic [3:0]         idx_b;
    logic [TABLE_W-1:0] ea;
    logic [TABLE_W-1:0] eb;
    ea = '0;
    eb = '0;
    for (int mt = 0; mt < TABLE_W; mt++) begin
      m     = 4'(mt);
      idx_a = '0;
      idx_b = '0;
      for (int v = 0; v < 4; v++) begin
        if (3'(v) < walk.sa) idx_a[v] = m[walk.ma[v]];
        if (3'(v) < walk.sb) idx_b[v] = m[walk.mb[v]];
      end
      ea[mt] = walk.ta[idx_a];
      eb[mt] = walk.tb[idx_b];
    end
    for (int s = 0; s < 4; s++) begin
      if (3'(s) < walk.n) begin
        trim_next.res[s] = walk.sel[s][2] ? walk.lb[walk.sel[s][1:0]]
                                          : walk.la[walk.sel[s][1:0]];
      end else begin
        trim_next.res[s] = '0;
      end
    end
    trim_next.t    = ea & eb;
    trim_next.fail = walk.fail;
    trim_next.n    = walk.n;
    trim_next.k    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    trim <= trim_next;
  end

endmodule

// File: sv/cam4_trim.sv
module cam4_trim
  import cam4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  trim_stage_t cur,
  output logic        out_valid,
  output trim_stage_t nxt
);

  trim_stage_t nxt_next;

  // two steps of the trim walk: keep a needed variable, drop an unneeded one
  always_comb begin
    nxt_next = cur;
    for (int step = 0; step < 2; step++) begin
      if (nxt_next.k < nxt_next.n) begin
        if (var_matters(nxt_next.t, nxt_next.k[1:0])) begin
          nxt_next.k = nxt_next.k + 3'd1;
        end else begin
          nxt_next.t = drop_var(nxt_next.t, nxt_next.k[1:0]);
          for (int q = 0; q < 3; q++) begin
            if (3'(q) >= nxt_next.k) nxt_next.res[q] = nxt_next.res[q + 1];
          end
          nxt_next.n = nxt_next.n - 3'd1;
          nxt_next.res[nxt_next.n[1:0]] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    nxt <= nxt_next;
  end

endmodule

// File: sv/cut_and_merge_4.sv
// AND of two cuts of up to four leaves each, one item accepted per clock.
// busy is high only while rst is asserted, so a new item may be started in
// every cycle. The result of an item appears on result with done high for
// exactly one cycle; the path is an input register, leaf compare, merge walk,
// table expansion and two trim stages of two variables each. Results come out
// in the order items went in. An item whose leaf union exceeds four leaves
// returns feasible low with all other result fields zero.
module cut_and_merge_4
  import cam4_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cut_pair_t     pair,
  output logic          done,
  output merge_result_t result
);

  logic        in_valid;
  cut_pair_t   in_pair;
  logic        walk_valid;
  walk_stage_t walk;
  logic        exp_valid;
  trim_stage_t exp_out;
  logic        trim1_valid;
  trim_stage_t trim1;
  logic        trim2_valid;
  trim_stage_t trim2;

  assign busy = rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_pair <= pair;
  end

  cam4_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .pair      (in_pair),
    .out_valid (walk_valid),
    .walk      (walk)
  );

  cam4_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (walk_valid),
    .walk      (walk),
    .out_valid (exp_valid),
    .trim      (exp_out)
  );

  cam4_trim u_trim_lo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exp_valid),
    .cur       (exp_out),
    .out_valid (trim1_valid),
    .nxt       (trim1)
  );

  cam4_trim u_trim_hi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trim1_valid),
    .cur       (trim1),
    .out_valid (trim2_valid),
    .nxt       (trim2)
  );

  // result item, all zero when the union does not fit
  always_comb begin
    done = trim2_valid;
    if (trim2.fail) begin
      result = '0;
    end else begin
      result.feasible        = 1'b1;
      result.size_out        = trim2.n;
      result.leaves_out_low  = {trim2.res[1], trim2.res[0]};
      result.leaves_out_high = {trim2.res[3], trim2.res[2]};
      result.table_out       = trim2.t;
    end
  end

endmodule
